// ----- rtl/tdn_pkg.sv -----
// Shared types and constants for the tree-discovery neighbour state machine.
package tdn_pkg;

    localparam int unsigned PADDR_W  = 4;
    localparam int unsigned PDATA_W  = 32;
    localparam int unsigned DELAY_W  = 24;
    localparam int unsigned COUNT_W  = 32;

    localparam logic [1:0] REG_OWN_DEPTH     = 2'd0;
    localparam logic [1:0] REG_OWN_TREE_PREF = 2'd1;
    localparam logic [1:0] REG_INGRESS       = 2'd2;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_CANDIDATE  = 3'd1,
        ST_CURRENT    = 3'd2,
        ST_HELD_UP    = 3'd3,
        ST_HELD_DOWN  = 3'd4,
        ST_COLLISION  = 3'd5,
        ST_ADMIN_DOWN = 3'd6
    } tdn_state_t;

    typedef enum logic [2:0] {
        OP_NEW_NEIGHBOR     = 3'd0,
        OP_JOIN             = 3'd1,
        OP_LEAVE            = 3'd2,
        OP_ADVERT_TIMEOUT   = 3'd3,
        OP_TREEHOP_EXPIRED  = 3'd4,
        OP_HOLDDOWN_EXPIRED = 3'd5,
        OP_COLLISION_ADVERT = 3'd6,
        OP_ADMIN_TOGGLE     = 3'd7
    } tdn_op_t;

    typedef struct packed {
        tdn_op_t     operation;
        logic        has_tree_info;
        logic [7:0]  nbr_depth;
        logic [31:0] nbr_tree_pref;
        logic [15:0] nbr_hop_delay;
        logic        same_tree;
        logic        expire_timer_running;
    } tdn_in_t;

    typedef struct packed {
        tdn_state_t         new_state;
        logic               state_changed;
        logic               start_treehop;
        logic [DELAY_W-1:0] treehop_delay;
        logic               cancel_treehop;
        logic               start_holddown;
        logic               add_route;
        logic               delete_route;
        logic               bump_sequence;
        logic               free_neighbor;
        logic               rerun_discovery;
    } tdn_out_t;

    typedef struct packed {
        logic [7:0]  own_depth;
        logic [31:0] own_tree_pref;
        logic        ingress_interface;
    } tdn_cfg_t;

    typedef struct packed {
        logic       wr;
        tdn_state_t prev_state;
    } tdn_log_t;

endpackage

// ----- rtl/tdn_cfg.sv -----
// Configuration register file behind the APB-style port.
module tdn_cfg
    import tdn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output tdn_cfg_t           cfg
);

    logic [7:0]  own_depth_reg;
    logic [7:0]  own_depth_next;
    logic [31:0] own_tree_pref_reg;
    logic [31:0] own_tree_pref_next;
    logic        ingress_reg;
    logic        ingress_next;
    logic        wr_en;
    logic [1:0]  reg_index;

    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_comb
    begin
        own_depth_next     = own_depth_reg;
        own_tree_pref_next = own_tree_pref_reg;
        ingress_next       = ingress_reg;
        if (wr_en)
        begin
            case (reg_index)
                REG_OWN_DEPTH:     own_depth_next     = pwdata[7:0];
                REG_OWN_TREE_PREF: own_tree_pref_next = pwdata;
                REG_INGRESS:       ingress_next       = pwdata[0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_depth_reg     <= '0;
            own_tree_pref_reg <= '0;
            ingress_reg       <= 1'b0;
        end
        else
        begin
            own_depth_reg     <= own_depth_next;
            own_tree_pref_reg <= own_tree_pref_next;
            ingress_reg       <= ingress_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_OWN_DEPTH:     prdata = {24'd0, own_depth_reg};
            REG_OWN_TREE_PREF: prdata = own_tree_pref_reg;
            REG_INGRESS:       prdata = {31'd0, ingress_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.own_depth         = own_depth_reg;
    assign cfg.own_tree_pref     = own_tree_pref_reg;
    assign cfg.ingress_interface = ingress_reg;

endmodule

// ----- rtl/tdn_step.sv -----
// Neighbour state register with next-state and command logic for one event.
module tdn_step
    import tdn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  tdn_in_t  item,
    input  tdn_cfg_t cfg,
    output tdn_out_t result,
    output tdn_log_t log_wr
);

    tdn_state_t         state_reg;
    tdn_state_t         state_next;
    logic [DELAY_W-1:0] product;
    logic [DELAY_W-1:0] delay;
    logic               collide;
    logic               not_root;
    logic               s_th;
    logic               c_th;
    logic               s_hd;
    logic               add;
    logic               del;
    logic               bump;
    logic               freed;
    logic               changed;

    assign product  = DELAY_W'(item.nbr_depth) * DELAY_W'(item.nbr_hop_delay);
    assign delay    = item.has_tree_info ? product : '0;
    assign not_root = (cfg.own_depth != 8'd0);
    assign collide  = cfg.ingress_interface && item.has_tree_info
                      && (item.nbr_depth == cfg.own_depth)
                      && (item.nbr_tree_pref < cfg.own_tree_pref);

    always_comb
    begin
        state_next = state_reg;
        if (item.operation == OP_ADMIN_TOGGLE
            && (state_reg inside {[ST_CANDIDATE:ST_COLLISION]}))
        begin
            state_next = ST_ADMIN_DOWN;
        end
        else if (item.operation == OP_ADVERT_TIMEOUT
                 && (state_reg inside {[ST_CANDIDATE:ST_HELD_UP]}))
        begin
            state_next = ST_HELD_DOWN;
        end
        else
        begin
            case (state_reg)
                ST_NONE:
                begin
                    if (item.operation == OP_NEW_NEIGHBOR)
                        state_next = collide ? ST_COLLISION : ST_CANDIDATE;
                end
                ST_CANDIDATE:
                begin
                    if (item.operation == OP_JOIN)
                        state_next = (item.has_tree_info && item.same_tree)
                                     ? ST_CURRENT : ST_HELD_UP;
                end
                ST_CURRENT:
                begin
                    if (item.operation == OP_LEAVE)
                        state_next = (item.has_tree_info && !item.same_tree)
                                     ? ST_CANDIDATE : ST_HELD_DOWN;
                end
                ST_HELD_UP:
                begin
                    if (item.operation == OP_TREEHOP_EXPIRED)
                        state_next = ST_CURRENT;
                end
                ST_HELD_DOWN:
                begin
                    if (item.operation == OP_HOLDDOWN_EXPIRED)
                        state_next = item.expire_timer_running
                                     ? ST_CANDIDATE : ST_NONE;
                end
                ST_COLLISION:
                begin
                    if (item.operation == OP_COLLISION_ADVERT)
                        state_next = ST_CANDIDATE;
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        s_th  = 1'b0;
        c_th  = 1'b0;
        s_hd  = 1'b0;
        add   = 1'b0;
        del   = 1'b0;
        bump  = 1'b0;
        freed = 1'b0;
        if (item.operation == OP_ADMIN_TOGGLE
            && (state_reg inside {[ST_CANDIDATE:ST_COLLISION]}))
        begin
            s_th = 1'b0;
        end
        else if (item.operation == OP_ADVERT_TIMEOUT
                 && (state_reg inside {[ST_CANDIDATE:ST_HELD_UP]}))
        begin
            bump = item.has_tree_info;
            s_hd = 1'b1;
        end
        else
        begin
            case (state_reg)
                ST_CANDIDATE:
                begin
                    if (item.operation == OP_JOIN)
                    begin
                        if (item.has_tree_info && item.same_tree)
                            add = not_root;
                        else
                            s_th = 1'b1;
                    end
                end
                ST_CURRENT:
                begin
                    if (item.operation == OP_LEAVE
                        && !(item.has_tree_info && !item.same_tree))
                    begin
                        bump = item.has_tree_info;
                        s_hd = 1'b1;
                        del  = 1'b1;
                    end
                end
                ST_HELD_UP:
                begin
                    if (item.operation == OP_JOIN)
                    begin
                        c_th = 1'b1;
                        s_th = 1'b1;
                    end
                    else if (item.operation == OP_TREEHOP_EXPIRED)
                    begin
                        add = not_root;
                    end
                end
                ST_HELD_DOWN:
                begin
                    if (item.operation == OP_HOLDDOWN_EXPIRED)
                        freed = !item.expire_timer_running;
                end
                default:
                begin
                    s_th = 1'b0;
                end
            endcase
        end
    end

    assign changed = (state_next != state_reg);

    assign result.new_state       = state_next;
    assign result.state_changed   = changed;
    assign result.start_treehop   = s_th;
    assign result.treehop_delay   = s_th ? delay : '0;
    assign result.cancel_treehop  = c_th;
    assign result.start_holddown  = s_hd;
    assign result.add_route       = add;
    assign result.delete_route    = del;
    assign result.bump_sequence   = bump;
    assign result.free_neighbor   = freed;
    assign result.rerun_discovery = !freed && (state_reg == ST_HELD_DOWN)
                                    && (state_next != ST_HELD_DOWN);

    assign log_wr.wr         = advance && changed && !freed;
    assign log_wr.prev_state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_NONE;
        else if (advance)
            state_reg <= state_next;
    end

endmodule

// ----- rtl/tdn_log.sv -----
// Change counter and ring of previous neighbour states.
module tdn_log
    import tdn_pkg::*;
#(
    parameter int unsigned LOG_DEPTH = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  tdn_log_t log_wr
);

    localparam int unsigned PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(LOG_DEPTH - 1);

    logic [COUNT_W-1:0] change_count_reg;
    logic [COUNT_W-1:0] change_count_next;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    tdn_state_t         log_mem [LOG_DEPTH];

    always_comb
    begin
        change_count_next = change_count_reg;
        ptr_next          = ptr_reg;
        if (log_wr.wr)
        begin
            change_count_next = change_count_reg + COUNT_W'(1);
            ptr_next          = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            change_count_reg <= '0;
            ptr_reg          <= '0;
        end
        else
        begin
            change_count_reg <= change_count_next;
            ptr_reg          <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (log_wr.wr)
            log_mem[ptr_reg] <= log_wr.prev_state;
    end

endmodule

// ----- rtl/tree_discovery_neighbor_fsm.sv -----
// Top level of the tree-discovery neighbour state machine.
// Each accepted event is captured in an input register, stepped through the neighbour
// state machine and the 8x16 tree-hop delay multiplier combinationally, and lands in a
// result register: out_valid rises once the event has reached the result register, and a
// new event can be accepted every cycle while out_ready is high. A result waiting for
// out_ready leaves room for one more event in the input register, then in_ready drops.
// The neighbour state advances when an event moves from the input register into the
// result register. Registers (APB, 4-byte stride): 0 own_depth, 1 own_tree_pref,
// 2 ingress_interface; write them only while no transaction is in flight.
module tree_discovery_neighbor_fsm
    import tdn_pkg::*;
#(
    parameter int unsigned LOG_DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  tdn_in_t            in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tdn_out_t           out_item
);

    tdn_cfg_t cfg;
    tdn_log_t log_wr;
    tdn_out_t result;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    tdn_in_t  s1_item_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    tdn_out_t out_item_reg;
    logic     advance;
    logic     in_take;

    assign pready = 1'b1;

    tdn_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tdn_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (result),
        .log_wr  (log_wr)
    );

    tdn_log #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .log_wr (log_wr)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_item;
        if (advance)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("stepped transaction did not reach the result register");

    a_free_to_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.free_neighbor |-> out_item_reg.new_state == ST_NONE)
        else $error("freed neighbour not returned to None");

    a_delay_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.start_treehop |-> out_item_reg.treehop_delay == '0)
        else $error("tree-hop delay without timer start");

    a_rerun_changed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.rerun_discovery |-> out_item_reg.state_changed)
        else $error("rediscovery without state change");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("empty input register refused a transaction");

endmodule

// ----- test/tree_discovery_neighbor_fsm_tb.sv -----
// Self-checking testbench for the tree-discovery neighbour state machine.
`timescale 1ns / 100ps

module tree_discovery_neighbor_fsm_tb
    import tdn_pkg::*;
();

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASE_ITEMS = 210;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    tdn_in_t            in_item = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    tdn_out_t           out_item;

    tdn_in_t    event_queue[$];
    tdn_out_t   neighbor_updates[$];

    tdn_state_t nbr_state = ST_NONE;
    logic [7:0]  cfg_depth = '0;
    logic [31:0] cfg_pref = '0;
    logic        cfg_ingress = 1'b0;

    int items_offered = 0;
    int items_taken = 0;
    int results_seen = 0;
    int fail_count = 0;
    int stalled_cycles = 0;
    int tx_gap = 0;
    int tx_calm = 0;
    int rx_stall = 0;
    int rx_calm = 0;
    int rx_hold_left = 0;
    int next_hold_at = 300;

    tree_discovery_neighbor_fsm i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tdn_out_t next_neighbor_update(tdn_in_t ev);
        tdn_out_t           u;
        tdn_state_t         prev;
        tdn_state_t         nxt;
        logic [DELAY_W-1:0] hop_delay;
        u = '0;
        prev = nbr_state;
        nxt = prev;
        hop_delay = ev.has_tree_info ?
            DELAY_W'(ev.nbr_depth) * DELAY_W'(ev.nbr_hop_delay) : '0;
        if (ev.operation == OP_ADMIN_TOGGLE && prev >= ST_CANDIDATE && prev <= ST_COLLISION)
            nxt = ST_ADMIN_DOWN;
        else if (ev.operation == OP_ADVERT_TIMEOUT && prev >= ST_CANDIDATE
                 && prev <= ST_HELD_UP)
        begin
            u.bump_sequence = ev.has_tree_info;
            u.start_holddown = 1'b1;
            nxt = ST_HELD_DOWN;
        end
        else
        begin
            case (prev)
                ST_NONE:
                    if (ev.operation == OP_NEW_NEIGHBOR)
                    begin
                        if (cfg_ingress && ev.has_tree_info && ev.nbr_depth == cfg_depth
                            && ev.nbr_tree_pref < cfg_pref)
                            nxt = ST_COLLISION;
                        else
                            nxt = ST_CANDIDATE;
                    end
                ST_CANDIDATE:
                    if (ev.operation == OP_JOIN)
                    begin
                        if (ev.has_tree_info && ev.same_tree)
                        begin
                            u.add_route = (cfg_depth != 0);
                            nxt = ST_CURRENT;
                        end
                        else
                        begin
                            u.start_treehop = 1'b1;
                            u.treehop_delay = hop_delay;
                            nxt = ST_HELD_UP;
                        end
                    end
                ST_CURRENT:
                    if (ev.operation == OP_LEAVE)
                    begin
                        if (ev.has_tree_info && !ev.same_tree)
                            nxt = ST_CANDIDATE;
                        else
                        begin
                            u.bump_sequence = ev.has_tree_info;
                            u.start_holddown = 1'b1;
                            u.delete_route = 1'b1;
                            nxt = ST_HELD_DOWN;
                        end
                    end
                ST_HELD_UP:
                    if (ev.operation == OP_JOIN)
                    begin
                        u.cancel_treehop = 1'b1;
                        u.start_treehop = 1'b1;
                        u.treehop_delay = hop_delay;
                    end
                    else if (ev.operation == OP_TREEHOP_EXPIRED)
                    begin
                        u.add_route = (cfg_depth != 0);
                        nxt = ST_CURRENT;
                    end
                ST_HELD_DOWN:
                    if (ev.operation == OP_HOLDDOWN_EXPIRED)
                    begin
                        if (!ev.expire_timer_running)
                        begin
                            u.free_neighbor = 1'b1;
                            nxt = ST_NONE;
                        end
                        else
                            nxt = ST_CANDIDATE;
                    end
                ST_COLLISION:
                    if (ev.operation == OP_COLLISION_ADVERT)
                        nxt = ST_CANDIDATE;
                default:
                    ;
            endcase
        end
        u.new_state = nxt;
        u.state_changed = (nxt != prev);
        u.rerun_discovery = !u.free_neighbor && prev == ST_HELD_DOWN && nxt != ST_HELD_DOWN;
        nbr_state = nxt;
        return u;
    endfunction

    task automatic note_failure(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        if (fail_count < 10)
            $display("mismatch at result %0d: %s expected %0h got %0h",
                     results_seen, what, want, got);
        fail_count++;
    endtask

    task automatic check_update(input tdn_out_t want, input tdn_out_t got);
        if (want.new_state !== got.new_state)
            note_failure("new_state", 32'(want.new_state), 32'(got.new_state));
        if (want.state_changed !== got.state_changed)
            note_failure("state_changed", 32'(want.state_changed), 32'(got.state_changed));
        if (want.start_treehop !== got.start_treehop)
            note_failure("start_treehop", 32'(want.start_treehop), 32'(got.start_treehop));
        if (want.treehop_delay !== got.treehop_delay)
            note_failure("treehop_delay", 32'(want.treehop_delay), 32'(got.treehop_delay));
        if (want.cancel_treehop !== got.cancel_treehop)
            note_failure("cancel_treehop", 32'(want.cancel_treehop),
                         32'(got.cancel_treehop));
        if (want.start_holddown !== got.start_holddown)
            note_failure("start_holddown", 32'(want.start_holddown),
                         32'(got.start_holddown));
        if (want.add_route !== got.add_route)
            note_failure("add_route", 32'(want.add_route), 32'(got.add_route));
        if (want.delete_route !== got.delete_route)
            note_failure("delete_route", 32'(want.delete_route), 32'(got.delete_route));
        if (want.bump_sequence !== got.bump_sequence)
            note_failure("bump_sequence", 32'(want.bump_sequence), 32'(got.bump_sequence));
        if (want.free_neighbor !== got.free_neighbor)
            note_failure("free_neighbor", 32'(want.free_neighbor), 32'(got.free_neighbor));
        if (want.rerun_discovery !== got.rerun_discovery)
            note_failure("rerun_discovery", 32'(want.rerun_discovery),
                         32'(got.rerun_discovery));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic tdn_op_t pick_chain_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return OP_JOIN;
        else if (r < 40)
            return OP_TREEHOP_EXPIRED;
        else if (r < 60)
            return OP_LEAVE;
        else if (r < 70)
            return OP_ADVERT_TIMEOUT;
        else if (r < 85)
            return OP_HOLDDOWN_EXPIRED;
        else if (r < 95)
            return OP_COLLISION_ADVERT;
        else
            return OP_NEW_NEIGHBOR;
    endfunction

    function automatic tdn_in_t random_event(tdn_op_t op);
        tdn_in_t ev;
        int      r;
        ev.operation = op;
        ev.has_tree_info = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 9);
        if (r < 3)
            ev.nbr_depth = cfg_depth;
        else if (r == 3)
            ev.nbr_depth = 8'd0;
        else if (r == 4)
            ev.nbr_depth = 8'hFF;
        else
            ev.nbr_depth = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 9);
        if (r == 0)
            ev.nbr_tree_pref = 32'd0;
        else if (r == 1)
            ev.nbr_tree_pref = 32'hFFFF_FFFF;
        else if (r == 2)
            ev.nbr_tree_pref = cfg_pref;
        else if (r == 3)
            ev.nbr_tree_pref = cfg_pref - 32'd1;
        else
            ev.nbr_tree_pref = $urandom;
        r = $urandom_range(0, 9);
        if (r == 0)
            ev.nbr_hop_delay = 16'd0;
        else if (r == 1)
            ev.nbr_hop_delay = 16'hFFFF;
        else
            ev.nbr_hop_delay = 16'($urandom_range(0, 65535));
        ev.same_tree = 1'($urandom_range(0, 1));
        ev.expire_timer_running = 1'($urandom_range(0, 1));
        return ev;
    endfunction

    task automatic queue_event(input tdn_op_t op, input logic tio, input logic [7:0] depth,
                               input logic [31:0] pref, input logic [15:0] dly,
                               input logic same, input logic live);
        tdn_in_t ev;
        ev.operation = op;
        ev.has_tree_info = tio;
        ev.nbr_depth = depth;
        ev.nbr_tree_pref = pref;
        ev.nbr_hop_delay = dly;
        ev.same_tree = same;
        ev.expire_timer_running = live;
        event_queue.push_back(ev);
    endtask

    // Drive the neighbour back to None from any state short of AdminDown.
    task automatic queue_flush();
        tdn_in_t ev;
        event_queue.push_back(random_event(OP_COLLISION_ADVERT));
        ev = random_event(OP_NEW_NEIGHBOR);
        ev.has_tree_info = 1'b0;
        event_queue.push_back(ev);
        event_queue.push_back(random_event(OP_ADVERT_TIMEOUT));
        ev = random_event(OP_HOLDDOWN_EXPIRED);
        ev.expire_timer_running = 1'b0;
        event_queue.push_back(ev);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_OWN_DEPTH:     cfg_depth = value[7:0];
            REG_OWN_TREE_PREF: cfg_pref = value;
            REG_INGRESS:       cfg_ingress = value[0];
            default:           ;
        endcase
    endtask

    task automatic wait_idle();
        while (event_queue.size() != 0 || items_taken != items_offered
               || neighbor_updates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Driver: hold the payload until taken, then idle for the chosen gap.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && items_taken != items_offered))
        begin
            if (tx_gap > 0)
            begin
                in_valid <= 1'b0;
                tx_gap--;
            end
            else if (event_queue.size() != 0)
            begin
                in_item <= event_queue.pop_front();
                in_valid <= 1'b1;
                items_offered <= items_offered + 1;
                if (tx_calm > 0)
                begin
                    tx_calm--;
                    tx_gap = 0;
                end
                else
                begin
                    tx_gap = pick_gap();
                    if ($urandom_range(0, 39) == 0)
                        tx_calm = $urandom_range(20, 80);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, so the block fills and back-pressures its input.
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
        else if (results_seen >= next_hold_at)
        begin
            rx_hold_left <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + 800;
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
            out_ready <= 1'b0;
        else if (rx_stall > 0)
        begin
            out_ready <= 1'b0;
            rx_stall--;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_calm > 0)
                rx_calm--;
            else if ($urandom_range(0, 4) == 0)
            begin
                rx_stall = pick_gap();
                if ($urandom_range(0, 29) == 0)
                    rx_calm = $urandom_range(20, 80);
            end
        end
    end

    // Monitor: check each result transaction, predict on each input transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (neighbor_updates.size() == 0)
                    note_failure("result with no pending event, new_state", '0,
                                 32'(out_item.new_state));
                else
                    check_update(neighbor_updates.pop_front(), out_item);
            end
            if (in_valid && in_ready)
            begin
                items_taken <= items_taken + 1;
                neighbor_updates.push_back(next_neighbor_update(in_item));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
                stalled_cycles <= 0;
            else if (stalled_cycles >= STALL_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
            else
                stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial
    begin
        int         added;
        int         n;
        logic [7:0] depth;
        logic [31:0] pref;
        logic       ingress;
        tdn_in_t    ev;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: root router, no ingress flag.
        queue_event(OP_ADMIN_TOGGLE, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
        queue_event(OP_NEW_NEIGHBOR, 1'b1, 8'h00, 32'h0000_0000, 16'h0000, 1'b0, 1'b0);
        queue_event(OP_JOIN, 1'b1, 8'h10, 32'h1234_5678, 16'h0100, 1'b1, 1'b0);
        queue_event(OP_LEAVE, 1'b1, 8'h10, 32'h1234_5678, 16'h0100, 1'b0, 1'b0);
        queue_event(OP_JOIN, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1);
        queue_event(OP_JOIN, 1'b0, 8'hFF, 32'h0000_0000, 16'hFFFF, 1'b1, 1'b0);
        queue_event(OP_TREEHOP_EXPIRED, 1'b1, 8'h01, 32'h0000_0001, 16'h0001, 1'b1, 1'b1);
        queue_event(OP_LEAVE, 1'b0, 8'h00, 32'h0000_0000, 16'h0000, 1'b1, 1'b0);
        queue_event(OP_HOLDDOWN_EXPIRED, 1'b1, 8'h55, 32'hAAAA_AAAA, 16'h5555, 1'b0, 1'b1);
        queue_event(OP_ADVERT_TIMEOUT, 1'b1, 8'hAA, 32'h5555_5555, 16'hAAAA, 1'b1, 1'b1);
        queue_event(OP_HOLDDOWN_EXPIRED, 1'b0, 8'h00, 32'h0000_0000, 16'h0000, 1'b0, 1'b0);
        wait_idle();

        write_register(REG_OWN_DEPTH, 32'd255);
        write_register(REG_OWN_TREE_PREF, 32'hFFFF_FFFF);
        write_register(REG_INGRESS, 32'd1);
        queue_event(OP_NEW_NEIGHBOR, 1'b1, 8'hFF, 32'h0000_0000, 16'h0003, 1'b0, 1'b0);
        queue_event(OP_JOIN, 1'b1, 8'hFF, 32'h0000_0000, 16'h0003, 1'b1, 1'b0);
        queue_event(OP_COLLISION_ADVERT, 1'b1, 8'hFF, 32'h0000_0000, 16'h0003, 1'b0, 1'b1);
        queue_event(OP_JOIN, 1'b0, 8'h20, 32'h0000_0010, 16'h0040, 1'b1, 1'b0);
        queue_event(OP_ADVERT_TIMEOUT, 1'b0, 8'h20, 32'h0000_0010, 16'h0040, 1'b0, 1'b0);
        queue_event(OP_HOLDDOWN_EXPIRED, 1'b1, 8'h20, 32'h0000_0010, 16'h0040, 1'b1, 1'b0);
        queue_event(OP_NEW_NEIGHBOR, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'h0007, 1'b1, 1'b0);
        queue_event(OP_JOIN, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'h0007, 1'b1, 1'b0);
        queue_event(OP_ADVERT_TIMEOUT, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'h0007, 1'b1, 1'b0);
        queue_event(OP_HOLDDOWN_EXPIRED, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'h0007, 1'b1, 1'b1);
        queue_event(OP_TREEHOP_EXPIRED, 1'b1, 8'hFF, 32'hFFFF_FFFF, 16'h0007, 1'b1, 1'b1);
        wait_idle();

        for (int p = 0; p < 8; p++)
        begin
            if (p == 0)
                depth = 8'd0;
            else if (p == 1)
                depth = 8'd255;
            else if (p == 2)
                depth = 8'd1;
            else
                depth = 8'($urandom_range(0, 255));
            if (p % 3 == 0)
                pref = 32'hFFFF_FFFF;
            else if (p == 1)
                pref = 32'd0;
            else
                pref = $urandom;
            ingress = (p < 4) ? !p[0] : 1'($urandom_range(0, 1));
            write_register(REG_OWN_DEPTH, {24'd0, depth});
            write_register(REG_OWN_TREE_PREF, pref);
            write_register(REG_INGRESS, {31'd0, ingress});
            added = 0;
            while (added < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    n = $urandom_range(1, 6);
                    repeat (n)
                        event_queue.push_back(random_event(tdn_op_t'($urandom_range(0, 6))));
                    added += n;
                end
                else
                begin
                    queue_flush();
                    if ($urandom_range(0, 4) == 0)
                        event_queue.push_back(random_event(OP_ADMIN_TOGGLE));
                    event_queue.push_back(random_event(OP_NEW_NEIGHBOR));
                    n = $urandom_range(3, 10);
                    repeat (n)
                        event_queue.push_back(random_event(pick_chain_op()));
                    added += n + 5;
                end
            end
            wait_idle();
        end

        // AdminDown is terminal: enter it from one state, then show every event is ignored.
        write_register(REG_OWN_DEPTH, $urandom_range(1, 255));
        write_register(REG_OWN_TREE_PREF, $urandom | 32'd1);
        write_register(REG_INGRESS, 32'd1);
        queue_flush();
        ev = random_event(OP_NEW_NEIGHBOR);
        ev.has_tree_info = 1'b0;
        case ($urandom_range(1, 5))
            1:
                event_queue.push_back(ev);
            2:
            begin
                event_queue.push_back(ev);
                ev = random_event(OP_JOIN);
                ev.has_tree_info = 1'b1;
                ev.same_tree = 1'b1;
                event_queue.push_back(ev);
            end
            3:
            begin
                event_queue.push_back(ev);
                ev = random_event(OP_JOIN);
                ev.has_tree_info = 1'b0;
                event_queue.push_back(ev);
            end
            4:
            begin
                event_queue.push_back(ev);
                event_queue.push_back(random_event(OP_ADVERT_TIMEOUT));
            end
            default:
            begin
                ev.has_tree_info = 1'b1;
                ev.nbr_depth = cfg_depth;
                ev.nbr_tree_pref = 32'd0;
                event_queue.push_back(ev);
            end
        endcase
        event_queue.push_back(random_event(OP_ADMIN_TOGGLE));
        repeat (30)
            event_queue.push_back(random_event(tdn_op_t'($urandom_range(0, 7))));
        wait_idle();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
